### design/dtecf_pkg.sv
// ----------------------------------------------------------------------------
// dtecf_pkg: shared types and constants for the delay tap eye center finder
// Request and result payload structs, per-lane window mark record, defaults.
// ----------------------------------------------------------------------------
package dtecf_pkg;

	// field widths fixed by the interface
	localparam int LANE_W = 4;
	localparam int TAP_W  = 5;
	localparam int ERR_W  = 16;

	// default sizing
	localparam int NUM_LANES_DEF = 16;
	localparam int NUM_TAPS_DEF  = 32;

	// error count that means a clean tap
	localparam logic [ERR_W-1:0] ERR_NONE = '0;

	// one measurement request
	typedef struct packed {
		logic [LANE_W-1:0] lane;
		logic [TAP_W-1:0]  tap;
		logic              locked;
		logic [ERR_W-1:0]  error_count;
	} in_t;

	// one centering result
	typedef struct packed {
		logic [LANE_W-1:0] out_lane;
		logic [TAP_W-1:0]  best_tap;
		logic              found;
	} out_t;

	// per-lane window marks: start, stop and wraparound restart, each flagged
	typedef struct packed {
		logic             has_first_good;
		logic [TAP_W-1:0] first_good;
		logic             has_first_bad;
		logic [TAP_W-1:0] first_bad;
		logic             has_wrap_good;
		logic [TAP_W-1:0] wrap_good;
	} marks_t;

endpackage

### design/dtecf_update.sv
// ----------------------------------------------------------------------------
// dtecf_update: window mark update and eye centering
// Applies one measurement to a lane's marks and computes the centered tap
// from the updated marks.
// ----------------------------------------------------------------------------
module dtecf_update #(
	parameter int NUM_TAPS = dtecf_pkg::NUM_TAPS_DEF
) (
	input  dtecf_pkg::marks_t              cur,
	input  logic                           restart,
	input  logic                           good,
	input  logic [dtecf_pkg::TAP_W-1:0]    tap,
	output dtecf_pkg::marks_t              nxt,
	output logic [dtecf_pkg::TAP_W-1:0]    best_tap,
	output logic                           found
);
	import dtecf_pkg::*;

	localparam logic signed [7:0] TAPS_S = 8'(NUM_TAPS);

	marks_t           base;
	logic signed [7:0] lo;
	logic signed [7:0] hi;
	logic signed [7:0] sum;
	logic signed [7:0] sum_adj;
	logic signed [7:0] mid;
	logic signed [7:0] mid_wrap;

	// tap zero starts the lane anew
	assign base = restart ? '0 : cur;

	// mark update
	always_comb begin
		nxt = base;
		if (good) begin
			if (!base.has_first_good) begin
				nxt.first_good     = tap;
				nxt.has_first_good = 1'b1;
			end else if (base.has_first_bad && !base.has_wrap_good) begin
				nxt.wrap_good     = tap;
				nxt.has_wrap_good = 1'b1;
			end
		end else if (base.has_first_good && !base.has_first_bad) begin
			nxt.first_bad     = tap;
			nxt.has_first_bad = 1'b1;
		end
	end

	// window center, halved toward zero, wrapped back into range
	always_comb begin
		lo = nxt.has_wrap_good ? $signed({3'b000, nxt.wrap_good}) - TAPS_S
		                       : $signed({3'b000, nxt.first_good});
		hi = nxt.has_first_bad ? $signed({3'b000, nxt.first_bad}) : TAPS_S;
		sum      = hi + lo;
		sum_adj  = sum + $signed({7'd0, sum[7]});
		mid      = sum_adj >>> 1;
		mid_wrap = mid[7] ? mid + TAPS_S : mid;
	end

	assign found    = nxt.has_first_good;
	assign best_tap = nxt.has_first_good ? mid_wrap[TAP_W-1:0] : '0;

endmodule

### design/delay_tap_eye_center_finder.sv
// ----------------------------------------------------------------------------
// delay_tap_eye_center_finder: per-lane delay tap scan and eye centering
// Tracks the good window of each lane in a mark memory and reports the
// centered tap when the last tap of a scan arrives.
// ----------------------------------------------------------------------------
// latency: a request is held in the stage 1 register, and the result of a scan's last tap is
//   registered in the output register when stage 1 fires; throughput: one request per cycle
//   while the output is not stalled (mark memory read on accept, updated and written when stage 1 fires)
// reset: arst_n clears the pipeline and output valid flags; the mark memory is
//   not cleared, a lane's entry is defined once it has seen tap zero
module delay_tap_eye_center_finder #(
	parameter int NUM_LANES = dtecf_pkg::NUM_LANES_DEF,
	parameter int NUM_TAPS  = dtecf_pkg::NUM_TAPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dtecf_pkg::in_t    in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output dtecf_pkg::out_t   out_item
);
	import dtecf_pkg::*;

	localparam int LANE_AW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

	marks_t mem [NUM_LANES];

	logic              in_accept;
	logic              in_range;
	logic [LANE_AW-1:0] rd_addr;

	logic              valid_s1;
	in_t               item_s1;
	marks_t            rd_s1;
	logic [LANE_AW-1:0] addr_s1;

	logic              fwd_valid_q;
	logic [LANE_AW-1:0] fwd_addr_q;
	marks_t            fwd_data_q;

	marks_t            cur;
	marks_t            nxt;
	logic              good;
	logic              last_tap;
	logic              fire_s1;
	logic [TAP_W-1:0]  best_tap;
	logic              found;

	logic              out_valid_q;
	out_t              out_item_q;

	// handshake
	assign fire_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire_s1;
	assign in_accept = in_valid && in_ready;
	assign in_range  = (7'(in_item.lane) < 7'(NUM_LANES)) &&
	                   (7'(in_item.tap) < 7'(NUM_TAPS));
	assign rd_addr   = LANE_AW'(in_item.lane);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && in_range;
		end
	end

	// stage 1 payload and memory read
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_item;
			addr_s1 <= rd_addr;
			rd_s1   <= mem[rd_addr];
		end
	end

	// mark memory write back
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			mem[addr_s1] <= nxt;
		end
	end

	// last write kept for a read that raced it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (fire_s1) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= nxt;
		end
	end

	assign cur      = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_s1;
	assign good     = item_s1.locked && (item_s1.error_count == ERR_NONE);
	assign last_tap = 7'(item_s1.tap) == 7'(NUM_TAPS - 1);

	dtecf_update #(
		.NUM_TAPS (NUM_TAPS)
	) u_update (
		.cur      (cur),
		.restart  (item_s1.tap == '0),
		.good     (good),
		.tap      (item_s1.tap),
		.nxt      (nxt),
		.best_tap (best_tap),
		.found    (found)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_tap) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_tap) begin
			out_item_q.out_lane <= item_s1.lane;
			out_item_q.best_tap <= best_tap;
			out_item_q.found    <= found;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

### tb/sv/eye_center_sb_pkg.sv
// ----------------------------------------------------------------------------
// eye_center_sb_pkg: scoreboard for the delay tap eye center finder
// Keeps its own copy of the per-lane window marks, predicts the centered tap
// for every request that closes a scan, and checks results in arrival order.
// ----------------------------------------------------------------------------
package eye_center_sb_pkg;

	import dtecf_pkg::*;

	localparam int LAST_TAP = NUM_TAPS_DEF - 1;
	localparam int REPORT_LIMIT = 10;

	class eye_center_scoreboard;
		marks_t lane_marks [NUM_LANES_DEF];
		out_t   pending_centers [$];
		int     mismatches;

		function new();
			foreach (lane_marks[i]) lane_marks[i] = '0;
			mismatches = 0;
		endfunction

		// midpoint of the good window, wrapped windows give a negative start
		function logic [TAP_W-1:0] window_center(marks_t m);
			int lo;
			int hi;
			int mid;
			lo = int'(m.first_good);
			hi = m.has_first_bad ? int'(m.first_bad) : NUM_TAPS_DEF;
			if (m.has_wrap_good) lo = int'(m.wrap_good) - NUM_TAPS_DEF;
			mid = (hi + lo) / 2;
			if (mid < 0) mid += NUM_TAPS_DEF;
			return TAP_W'(mid);
		endfunction

		// apply one accepted request to the lane marks, queue a result on the last tap
		function void note_request(in_t req);
			marks_t m;
			logic   good;
			out_t   center;
			if (int'(req.lane) >= NUM_LANES_DEF || int'(req.tap) >= NUM_TAPS_DEF) return;
			m = lane_marks[req.lane];
			if (req.tap == '0) m = '0;
			good = req.locked && (req.error_count == ERR_NONE);
			if (good) begin
				if (!m.has_first_good) begin
					m.first_good     = req.tap;
					m.has_first_good = 1'b1;
				end else if (m.has_first_bad && !m.has_wrap_good) begin
					m.wrap_good     = req.tap;
					m.has_wrap_good = 1'b1;
				end
			end else if (m.has_first_good && !m.has_first_bad) begin
				m.first_bad     = req.tap;
				m.has_first_bad = 1'b1;
			end
			lane_marks[req.lane] = m;
			if (int'(req.tap) == LAST_TAP) begin
				center.out_lane = req.lane;
				center.found    = m.has_first_good;
				center.best_tap = m.has_first_good ? window_center(m) : '0;
				pending_centers.insert(pending_centers.size(), center);
			end
		endfunction

		// compare one accepted result with the oldest pending center
		function void check_result(out_t got);
			out_t want;
			if (pending_centers.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: lane %0d best_tap %0d found %0b",
						got.out_lane, got.best_tap, got.found);
				return;
			end
			want = pending_centers.pop_front();
			if (got.out_lane !== want.out_lane || got.best_tap !== want.best_tap ||
					got.found !== want.found) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display({"result mismatch: lane exp %0d got %0d, ",
						"best_tap exp %0d got %0d, found exp %0b got %0b"},
						want.out_lane, got.out_lane, want.best_tap, got.best_tap,
						want.found, got.found);
			end
		endfunction
	endclass

endpackage

### tb/sv/tb_delay_tap_eye_center_finder.sv
// ----------------------------------------------------------------------------
// tb_delay_tap_eye_center_finder: regression bench for the eye center finder
// Directed scans for edge windows, then interleaved random lane scans with
// broken sequences mixed in, random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_delay_tap_eye_center_finder;

	timeunit 1ns;
	timeprecision 1ps;

	import dtecf_pkg::*;
	import eye_center_sb_pkg::*;

	localparam int RANDOM_REQUESTS = 1626;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD = 400;
	localparam int TAIL_CYCLES = 10;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_item;
	logic out_valid;
	logic out_ready;
	out_t out_item;

	eye_center_scoreboard sb = new();

	int accepted_requests;
	int cycles_since_progress;
	int burst_left;
	logic [NUM_LANES_DEF-1:0] lane_started;
	int scan_pos [NUM_LANES_DEF];
	logic [NUM_TAPS_DEF-1:0] scan_mask [NUM_LANES_DEF];

	delay_tap_eye_center_finder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sample both handshakes at the edge and track progress
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_request(in_item);
				accepted_requests++;
			end
			if (out_valid && out_ready) sb.check_result(out_item);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				cycles_since_progress = 0;
			else
				cycles_since_progress++;
		end
	end

	// watchdog on cycles without any accepted request or result
	initial begin
		cycles_since_progress = 0;
		while (cycles_since_progress < STALL_LIMIT) @(posedge clk);
		$display("delay_tap_eye_center_finder regression: fail");
		$finish;
	end

	// receiver: ready stretches, random stalls, one long hold-off
	initial begin
		bit held_long;
		int span;
		held_long = 1'b0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held_long && accepted_requests >= 300) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				held_long = 1'b1;
			end else begin
				span = $urandom_range(1, 40);
				case ($urandom_range(0, 3))
					0: begin
						out_ready <= 1'b1;
						repeat (span) @(posedge clk);
					end
					3: begin
						out_ready <= 1'b0;
						repeat ($urandom_range(1, 6)) @(posedge clk);
					end
					default: begin
						repeat (span) begin
							out_ready <= ($urandom_range(0, 9) < 7);
							@(posedge clk);
						end
					end
				endcase
			end
		end
	end

	// offer one request and hold it until accepted
	task automatic send_request(input in_t req);
		in_item  <= req;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// sender bursts with random gaps, then one request
	task automatic offer(input int lane, input int tap, input logic locked,
			input logic [ERR_W-1:0] err);
		in_t req;
		req.lane        = LANE_W'(lane);
		req.tap         = TAP_W'(tap);
		req.locked      = locked;
		req.error_count = err;
		if (tap == 0) lane_started[lane] = 1'b1;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
		burst_left--;
		send_request(req);
	endtask

	// hold off the sender until every pending center has come back
	task automatic wait_for_centers();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_centers.size() != 0) @(posedge clk);
	endtask

	// one measurement, good or bad for one of several reasons
	task automatic offer_measurement(input int lane, input int tap, input logic good);
		if (good)
			offer(lane, tap, 1'b1, ERR_NONE);
		else
			case ($urandom_range(0, 3))
				0: offer(lane, tap, 1'b0, ERR_NONE);
				1: offer(lane, tap, 1'b1, 16'hffff);
				2: offer(lane, tap, 1'b1, ERR_W'($urandom_range(1, 65535)));
				default: offer(lane, tap, 1'b0, ERR_W'($urandom()));
			endcase
	endtask

	// good-tap pattern for one scan
	function automatic logic [NUM_TAPS_DEF-1:0] window_mask();
		int a;
		int b;
		int c;
		int d;
		logic [NUM_TAPS_DEF-1:0] m;
		a = $urandom_range(0, NUM_TAPS_DEF - 1);
		b = $urandom_range(a, NUM_TAPS_DEF - 1);
		c = $urandom_range(b, NUM_TAPS_DEF - 1);
		d = $urandom_range(c, NUM_TAPS_DEF - 1);
		m = '0;
		case ($urandom_range(0, 6))
			0: m = '0;
			1: m = '1;
			2: for (int t = a; t <= b; t++) m[t] = 1'b1;
			3: for (int t = 0; t < NUM_TAPS_DEF; t++) m[t] = (t < a) || (t > b);
			4: m = NUM_TAPS_DEF'($urandom());
			5: m[a] = 1'b1;
			default: for (int t = 0; t < NUM_TAPS_DEF; t++)
				m[t] = (t >= a && t < b) || (t > c && t <= d);
		endcase
		return m;
	endfunction

	// edge windows, wraparound, tap zero clearing and out-of-order taps
	task automatic run_directed();
		// all good, no stop mark
		offer(0, 0, 1'b1, ERR_NONE);
		offer(0, LAST_TAP, 1'b1, ERR_NONE);
		// no good tap at all
		offer(15, 0, 1'b1, 16'hffff);
		offer(15, LAST_TAP, 1'b0, ERR_NONE);
		// window that wraps, odd negative sum
		offer(3, 0, 1'b0, ERR_NONE);
		offer(3, 5, 1'b1, ERR_NONE);
		offer(3, 9, 1'b1, 16'h0001);
		offer(3, 20, 1'b1, ERR_NONE);
		offer(3, LAST_TAP, 1'b1, ERR_NONE);
		// stop on the last tap
		offer(7, 0, 1'b1, ERR_NONE);
		offer(7, LAST_TAP, 1'b0, 16'hffff);
		// taps out of order on the same lane
		offer(7, 0, 1'b0, ERR_NONE);
		offer(7, LAST_TAP, 1'b1, ERR_NONE);
		offer(7, 12, 1'b1, ERR_NONE);
		offer(7, 4, 1'b0, 16'h8000);
		offer(7, LAST_TAP, 1'b1, ERR_NONE);
		// tap zero wipes an earlier scan
		offer(9, 0, 1'b1, ERR_NONE);
		offer(9, 3, 1'b0, ERR_NONE);
		offer(9, 0, 1'b0, ERR_NONE);
		offer(9, LAST_TAP, 1'b1, ERR_NONE);
		// restart right after a one tap gap
		offer(12, 0, 1'b1, ERR_NONE);
		offer(12, 1, 1'b1, 16'h0001);
		offer(12, 2, 1'b1, ERR_NONE);
		offer(12, LAST_TAP, 1'b1, ERR_NONE);
	endtask

	// interleaved lane scans with broken sequences mixed in
	task automatic run_random();
		int lane;
		int tap;
		lane = 0;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == RANDOM_REQUESTS / 2) wait_for_centers();
			if ($urandom_range(0, 1) == 0) lane = $urandom_range(0, NUM_LANES_DEF - 1);
			if (lane_started[lane] && $urandom_range(0, 99) < 12) begin
				tap = $urandom_range(0, LAST_TAP);
				offer(lane, tap, 1'($urandom()),
					($urandom_range(0, 1) == 0) ? ERR_NONE : ERR_W'($urandom()));
			end else begin
				if (scan_pos[lane] == 0) scan_mask[lane] = window_mask();
				tap = scan_pos[lane];
				scan_pos[lane] = (tap == LAST_TAP) ? 0 : tap + 1;
				offer_measurement(lane, tap, scan_mask[lane][tap]);
			end
		end
	endtask

	// reset, stimulus, drain and verdict
	initial begin
		in_valid  <= 1'b0;
		in_item   <= '0;
		arst_n    <= 1'b0;
		accepted_requests = 0;
		burst_left = 0;
		lane_started = '0;
		foreach (scan_pos[i]) scan_pos[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		wait_for_centers();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_centers.size() == 0)
			$display("delay_tap_eye_center_finder regression: pass");
		else
			$display("delay_tap_eye_center_finder regression: fail");
		$finish;
	end

endmodule
